// File: rtl/core/sgsci_pkg.sv
// ----------------------------------------------------------------------------
// sgsci_pkg
// Shared types, character codes and the version string of the serial pin
// expander command interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package sgsci_pkg;

    // pin count of the expander and width of the pin fields on the ports
    localparam int NUM_PINS     = 28;
    localparam int PIN_FIELD_W  = 28;
    localparam int PULL_FIELD_W = 2 * PIN_FIELD_W;
    localparam int SEL_W        = 5;
    localparam int IDX_W        = 5;

    // pins handed to the spi bus
    localparam logic [PIN_FIELD_W-1:0] SPI_PIN_MASK = PIN_FIELD_W'(28'h0000E00);

    // command and response characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // pull mode codes
    localparam logic [1:0] PULL_NONE = 2'd0;
    localparam logic [1:0] PULL_UP   = 2'd1;
    localparam logic [1:0] PULL_DOWN = 2'd2;

    // version reply length and last character index
    localparam int VERSION_LEN = 25;
    localparam logic [IDX_W-1:0] VERSION_LAST = IDX_W'(VERSION_LEN - 1);

    // parse state of the command stream
    typedef enum logic [2:0] {
        PS_CMD  = 3'b001,
        PS_HIGH = 3'b010,
        PS_LOW  = 3'b100
    } t_parse;

    // interpreter state
    typedef struct packed {
        t_parse                    parse;
        logic [SEL_W-1:0]          sel;
        logic [3:0]                high_nibble;
        logic [PIN_FIELD_W-1:0]    drive;
        logic [PIN_FIELD_W-1:0]    dir;
        logic [PULL_FIELD_W-1:0]   pull;
        logic [PIN_FIELD_W-1:0]    claimed;
        logic                      spi_claimed;
    } t_state;

    // response descriptor of one command
    typedef struct packed {
        logic             is_version;
        logic             silent;
        logic [IDX_W-1:0] last_idx;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic             spi_go;
        logic [7:0]       spi_byte;
    } t_resp;

    // version string, one character per index
    function automatic logic [7:0] version_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h52;
            5'd1:    ch = 8'h54;
            5'd2:    ch = 8'h6B;
            5'd3:    ch = 8'h2E;
            5'd4:    ch = 8'h47;
            5'd5:    ch = 8'h50;
            5'd6:    ch = 8'h49;
            5'd7:    ch = 8'h4F;
            5'd8:    ch = 8'h20;
            5'd9:    ch = 8'h76;
            5'd10:   ch = 8'h32;
            5'd11:   ch = 8'h2E;
            5'd12:   ch = 8'h31;
            5'd13:   ch = 8'h20;
            5'd14:   ch = 8'h32;
            5'd15:   ch = 8'h30;
            5'd16:   ch = 8'h32;
            5'd17:   ch = 8'h36;
            5'd18:   ch = 8'h2D;
            5'd19:   ch = 8'h30;
            5'd20:   ch = 8'h34;
            5'd21:   ch = 8'h2D;
            5'd22:   ch = 8'h30;
            5'd23:   ch = 8'h37;
            5'd24:   ch = 8'h0A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sgsci_in_if.sv
// ----------------------------------------------------------------------------
// sgsci_in_if
// Command channel: one host byte with the sampled pin levels and spi reply.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgsci_in_if;

    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [27:0] pin_levels;
    logic [7:0]  spi_reply;

    modport source (output valid, output rx_byte, output pin_levels, output spi_reply,
                    input ready);
    modport sink (input valid, input rx_byte, input pin_levels, input spi_reply,
                  output ready);

endinterface

`default_nettype wire

// File: rtl/core/sgsci_out_if.sv
// ----------------------------------------------------------------------------
// sgsci_out_if
// Response channel: one response character with the pin settings.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgsci_out_if;

    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [7:0]  tx_char;
    logic        last;
    logic [27:0] pin_drive;
    logic [27:0] pin_output_enable;
    logic [55:0] pin_pull;
    logic        spi_owns_pins;
    logic        spi_start;
    logic [7:0]  spi_data;

    modport source (output valid, output char_valid, output tx_char, output last,
                    output pin_drive, output pin_output_enable, output pin_pull,
                    output spi_owns_pins, output spi_start, output spi_data,
                    input ready);
    modport sink (input valid, input char_valid, input tx_char, input last,
                  input pin_drive, input pin_output_enable, input pin_pull,
                  input spi_owns_pins, input spi_start, input spi_data,
                  output ready);

endinterface

`default_nettype wire

// File: rtl/core/sgsci_decode.sv
// ----------------------------------------------------------------------------
// sgsci_decode
// Next state and response descriptor for one command byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsci_decode
    import sgsci_pkg::*;
(
    input  var t_state                 i_state,
    input  var logic [7:0]             i_rx_byte,
    input  var logic [PIN_FIELD_W-1:0] i_pin_levels,
    input  var logic [7:0]             i_spi_reply,
    output t_state                     o_state,
    output t_resp                      o_resp
);

    // hex digit value, anything but a decimal digit maps to (c - 0x37) mod 16
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= CH_ZERO && c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n >= 4'd10) begin
            ch = 8'h37 + {4'd0, n};
        end else begin
            ch = CH_ZERO + {4'd0, n};
        end
        return ch;
    endfunction

    logic [PIN_FIELD_W-1:0] pin_mask;
    logic [SEL_W:0]         sel_inc;
    logic                   is_letter;
    logic                   is_action;
    logic                   level;

    assign pin_mask  = PIN_FIELD_W'(1) << i_state.sel;
    assign sel_inc   = {1'b0, i_state.sel} + (SEL_W+1)'(1);
    assign is_letter = (i_rx_byte >= CH_A_LO)
                       && ({1'b0, i_rx_byte} < 9'(int'(CH_A_LO) + NUM_PINS));
    assign is_action = i_rx_byte inside {CH_ZERO, CH_ONE, CH_I, CH_O, CH_QUERY,
                                         CH_U, CH_D, CH_N};
    assign level     = |(i_pin_levels & pin_mask);

    always_comb begin
        o_state = i_state;
        o_resp  = '{is_version: 1'b0, silent: 1'b1, last_idx: '0, c0: 8'h00,
                    c1: 8'h00, spi_go: 1'b0, spi_byte: 8'h00};

        if (i_rx_byte == CH_V) begin
            // version string, obeyed in every parse state
            o_state.parse     = PS_CMD;
            o_resp.is_version = 1'b1;
            o_resp.silent     = 1'b0;
            o_resp.last_idx   = VERSION_LAST;
        end else if (i_rx_byte == CH_R) begin
            // release every pin and the spi bus
            o_state.sel         = '0;
            o_state.drive       = '0;
            o_state.dir         = '0;
            o_state.pull        = '0;
            o_state.claimed     = '0;
            o_state.spi_claimed = 1'b0;
            o_state.parse       = PS_CMD;
            o_resp.silent       = 1'b0;
            o_resp.last_idx     = IDX_W'(1);
            o_resp.c0           = CH_O;
            o_resp.c1           = CH_K;
        end else begin
            case (i_state.parse)
                PS_HIGH: begin
                    o_state.high_nibble = hex_value(i_rx_byte);
                    o_state.parse       = PS_LOW;
                end
                PS_LOW: begin
                    // take the spi pins back if the bus does not hold them
                    if (!i_state.spi_claimed) begin
                        o_state.drive   = i_state.drive & ~SPI_PIN_MASK;
                        o_state.dir     = i_state.dir & ~SPI_PIN_MASK;
                        o_state.claimed = i_state.claimed & ~SPI_PIN_MASK;
                        for (int i = 0; i < PIN_FIELD_W; i++) begin
                            if (SPI_PIN_MASK[i]) begin
                                o_state.pull[2*i +: 2] = PULL_NONE;
                            end
                        end
                        o_state.spi_claimed = 1'b1;
                    end
                    o_state.parse   = PS_CMD;
                    o_resp.spi_go   = 1'b1;
                    o_resp.spi_byte = {i_state.high_nibble, hex_value(i_rx_byte)};
                    o_resp.silent   = 1'b0;
                    o_resp.last_idx = IDX_W'(1);
                    o_resp.c0       = hex_char(i_spi_reply[7:4]);
                    o_resp.c1       = hex_char(i_spi_reply[3:0]);
                end
                default: begin
                    o_state.parse = PS_CMD;
                    if (is_letter) begin
                        o_state.sel = SEL_W'(i_rx_byte - CH_A_LO);
                    end else if (is_action) begin
                        // claim the selected pin as a gpio
                        if (!(|(i_state.claimed & pin_mask))) begin
                            if (|(pin_mask & SPI_PIN_MASK)) begin
                                o_state.spi_claimed = 1'b0;
                            end
                            o_state.claimed = i_state.claimed | pin_mask;
                        end
                        case (i_rx_byte)
                            CH_ZERO: o_state.drive = i_state.drive & ~pin_mask;
                            CH_ONE:  o_state.drive = i_state.drive | pin_mask;
                            CH_O:    o_state.dir   = i_state.dir | pin_mask;
                            CH_I:    o_state.dir   = i_state.dir & ~pin_mask;
                            CH_U, CH_D, CH_N: begin
                                for (int i = 0; i < PIN_FIELD_W; i++) begin
                                    if (pin_mask[i]) begin
                                        o_state.pull[2*i +: 2] =
                                            (i_rx_byte == CH_U) ? PULL_UP :
                                            (i_rx_byte == CH_D) ? PULL_DOWN : PULL_NONE;
                                    end
                                end
                            end
                            CH_QUERY: begin
                                o_resp.silent   = 1'b0;
                                o_resp.last_idx = IDX_W'(3);
                                o_resp.c0       = CH_A_LO + {3'd0, i_state.sel};
                                o_resp.c1       = level ? CH_ONE : CH_ZERO;
                            end
                            default: ;
                        endcase
                        // advance the selection with wrap
                        if (sel_inc >= (SEL_W+1)'(NUM_PINS)) begin
                            o_state.sel = '0;
                        end else begin
                            o_state.sel = sel_inc[SEL_W-1:0];
                        end
                    end else if (i_rx_byte == CH_TILDE) begin
                        o_state.parse = PS_HIGH;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/serial_gpio_spi_command_interpreter_unit.sv
// ----------------------------------------------------------------------------
// serial_gpio_spi_command_interpreter_unit
// Host command interpreter of a serial pin expander with spi passthrough.
//
//   channel   direction  content
//   i_cmd     in         host byte, sampled pin levels, spi reply
//   o_rsp     out        response character, last flag, pin settings, spi
//
// A command byte waits in the input register until the last response has
// drained; then its state update and response register are loaded together.
// Each command gives one transfer per response character (one for a silent
// command, 25 for the version string), paced by the character counter.
// The next command is taken into the input register while a response drains.
// Synchronous active-low reset, no clearing pass; stalls on o_rsp
// hold the current character and back up into i_cmd.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_gpio_spi_command_interpreter_unit
    import sgsci_pkg::*;
(
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    sgsci_in_if.sink    i_cmd,
    sgsci_out_if.source o_rsp
);

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_rx_byte;
    logic [PIN_FIELD_W-1:0] r_pin_levels;
    logic [7:0]             r_spi_reply;

    // interpreter state and current response
    t_state                 r_state;
    t_state                 n_state;
    t_resp                  r_resp;
    t_resp                  n_resp;
    logic                   r_rsp_valid;
    logic [IDX_W-1:0]       r_idx;

    logic                   rsp_last;
    logic                   rsp_xfer;
    logic                   load;
    logic [7:0]             list_char;

    sgsci_decode u_decode (
        .i_state      (r_state),
        .i_rx_byte    (r_rx_byte),
        .i_pin_levels (r_pin_levels),
        .i_spi_reply  (r_spi_reply),
        .o_state      (n_state),
        .o_resp       (n_resp)
    );

    // handshake control
    assign rsp_last    = (r_idx == r_resp.last_idx);
    assign rsp_xfer    = r_rsp_valid && o_rsp.ready;
    assign load        = r_in_valid && (!r_rsp_valid || (rsp_xfer && rsp_last));
    assign i_cmd.ready = !r_in_valid || load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_rx_byte    <= i_cmd.rx_byte;
            r_pin_levels <= i_cmd.pin_levels;
            r_spi_reply  <= i_cmd.spi_reply;
        end
    end

    // state update and response load, character counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{parse: PS_CMD, sel: '0, high_nibble: '0, drive: '0,
                             dir: '0, pull: '0, claimed: '0, spi_claimed: 1'b0};
            r_rsp_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            r_state     <= n_state;
            r_rsp_valid <= 1'b1;
            r_idx       <= '0;
        end else if (rsp_xfer) begin
            r_rsp_valid <= !rsp_last;
            r_idx       <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_resp <= n_resp;
        end
    end

    // character of a short reply
    always_comb begin
        case (r_idx[1:0])
            2'd0:    list_char = r_resp.c0;
            2'd1:    list_char = r_resp.c1;
            2'd2:    list_char = CH_CR;
            default: list_char = CH_LF;
        endcase
    end

    // response outputs
    assign o_rsp.valid             = r_rsp_valid;
    assign o_rsp.char_valid        = !r_resp.silent;
    assign o_rsp.tx_char           = r_resp.silent     ? 8'h00 :
                                     r_resp.is_version ? version_char(r_idx) : list_char;
    assign o_rsp.last              = rsp_last;
    assign o_rsp.pin_drive         = r_state.drive;
    assign o_rsp.pin_output_enable = r_state.dir;
    assign o_rsp.pin_pull          = r_state.pull;
    assign o_rsp.spi_owns_pins     = r_state.spi_claimed;
    assign o_rsp.spi_start         = r_resp.spi_go && (r_idx == '0);
    assign o_rsp.spi_data          = (r_resp.spi_go && (r_idx == '0)) ? r_resp.spi_byte
                                                                       : 8'h00;

endmodule

`default_nettype wire
